FILE: hw/rtl/ajcd_pkg.sv
// shared constants, types and helpers for the accelerometer jerk collision detector
// used by accel_jerk_collision_detect; no dependencies
`default_nettype none

package ajcd_pkg;

    // fixed field widths
    localparam int IN_W     = 16;
    localparam int OUT_W    = 34;
    localparam int CFG_W    = 34;
    localparam int CFG_IDX_W = 3;

    // sizing
    localparam int WINDOW      = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 3;

    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int MAG_W    = SUM_W;
    localparam int STEP_W   = $clog2(MAG_W);
    localparam int DMAG_W   = SAMPLE_BITS + 1;
    localparam int TOT_W    = 2 * DMAG_W;
    localparam int CMP_W    = (TOT_W > OUT_W) ? TOT_W : OUT_W;
    localparam int CORR_W   = ((IN_W > SAMPLE_BITS) ? IN_W : SAMPLE_BITS) + 2;
    localparam int RAM_W    = AXES * SAMPLE_BITS;
    localparam int AX_W     = 2;

    localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);
    localparam logic [AX_W-1:0]   AX_LAST   = AX_W'(AXES);

    localparam logic [OUT_W-1:0] CHANGE_MAX   = {OUT_W{1'b1}};
    localparam logic [CFG_W-1:0] THRESH_RESET = CFG_W'(34'd16777216);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_MEAN,
        ST_DELTA,
        ST_SQUARE,
        ST_DONE
    } state_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    // raw minus offset, clamped to the sample range
    function automatic sample_t sat_sample(input logic signed [IN_W-1:0] raw,
                                           input logic signed [IN_W-1:0] ofs);
        logic signed [CORR_W-1:0] diff;
        logic signed [CORR_W-1:0] hi;
        logic signed [CORR_W-1:0] lo;
        diff = CORR_W'(raw) - CORR_W'(ofs);
        hi   = CORR_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo   = -hi - CORR_W'(1);
        if (diff > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (diff < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return diff[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ajcd_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// standalone, no package dependency
`default_nettype none

module ajcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/accel_jerk_collision_detect.sv
// top level of the accelerometer jerk collision detector
// uses ajcd_pkg and one ajcd_ram instance for the sample window
`default_nettype none

// Takes one offset-corrected three-axis sample at a time, keeps the last WINDOW samples in a
// small ram, forms the per-axis mean over the samples present and flags a collision when the
// squared change of that mean exceeds the threshold register. Each item passes the divider,
// which takes one quotient bit per cycle for the three axis sums in parallel, and then one
// shared multiplier squaring the three axis deltas in turn; no new sample is taken meanwhile.
// A finished result sits in an output register, so the next sample is taken while it waits.
// The ring ram has no reset and needs no clearing pass: only entries already written are
// used. The user must write configuration only when idle; the block does not enforce it.
module accel_jerk_collision_detect (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [ajcd_pkg::IN_W-1:0]  accel_x,
    input  wire logic signed [ajcd_pkg::IN_W-1:0]  accel_y,
    input  wire logic signed [ajcd_pkg::IN_W-1:0]  accel_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   collision,
    output logic [ajcd_pkg::OUT_W-1:0]             change_sq,
    input  wire logic                              cfg_we,
    input  wire logic [ajcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ajcd_pkg::CFG_W-1:0]        cfg_data
);

    import ajcd_pkg::*;

    state_t state_reg, state_next;

    logic signed [IN_W-1:0] offset_reg [AXES];
    logic [CFG_W-1:0]       threshold_reg;

    sample_t             corr_reg  [AXES];
    sum_t                sum_reg   [AXES];
    sample_t             prev_reg  [AXES];
    sample_t             mean_reg  [AXES];
    logic [DMAG_W-1:0]   dmag_reg  [AXES];
    logic [MAG_W-1:0]    quo_reg   [AXES];
    logic [CNT_W-1:0]    rem_reg   [AXES];
    logic                neg_reg   [AXES];

    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [AX_W-1:0]     ax_reg;
    logic [TOT_W-1:0]    prod_reg;
    logic [TOT_W-1:0]    total_reg;

    logic                out_valid_reg;
    logic                collision_reg;
    logic [OUT_W-1:0]    change_reg;

    // fsm outputs
    logic                ram_re;
    logic                ram_we;
    logic                out_load;
    logic                in_take;

    logic [RAM_W-1:0]    ram_rdata;
    logic [RAM_W-1:0]    ram_wdata;

    logic                full;
    logic [CNT_W-1:0]    fill_next;
    sum_t                sum_next  [AXES];
    sample_t             old_smp   [AXES];
    logic [CMP_W-1:0]    total_ext;

    assign in_take = in_valid && !in_stall;
    assign full    = (fill_reg == FILL_FULL);
    assign fill_next = full ? fill_reg : fill_reg + CNT_W'(1);

    // ram word layout: x in the low bits
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            old_smp[a] = ram_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
            ram_wdata[a*SAMPLE_BITS +: SAMPLE_BITS] = corr_reg[a];
            // drop the oldest sample once the window is full
            sum_next[a] = sum_reg[a] + SUM_W'(corr_reg[a])
                          - (full ? SUM_W'(old_smp[a]) : SUM_W'(0));
        end
    end

    ajcd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DIVIDE;
            ST_DIVIDE: if (step_reg == STEP_LAST) state_next = ST_MEAN;
            ST_MEAN:   state_next = ST_DELTA;
            ST_DELTA:  state_next = ST_SQUARE;
            ST_SQUARE: if (ax_reg == AX_LAST) state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall = 1'b1;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_re   = in_valid;
            end
            ST_UPDATE: ram_we = 1'b1;
            ST_DONE:   out_load = !out_valid_reg || !out_stall;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= '0;
                sum_reg[a]    <= '0;
                prev_reg[a]   <= '0;
            end
            threshold_reg <= THRESH_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET_X:  offset_reg[0] <= cfg_data[IN_W-1:0];
                    REG_OFFSET_Y:  offset_reg[1] <= cfg_data[IN_W-1:0];
                    REG_OFFSET_Z:  offset_reg[2] <= cfg_data[IN_W-1:0];
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (state_reg == ST_UPDATE)
            begin
                for (int a = 0; a < AXES; a++)
                    sum_reg[a] <= sum_next[a];
                fill_reg <= fill_next;
                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
            end

            if (state_reg == ST_DELTA)
            begin
                for (int a = 0; a < AXES; a++)
                    prev_reg[a] <= mean_reg[a];
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                corr_reg[0] <= sat_sample(accel_x, offset_reg[0]);
                corr_reg[1] <= sat_sample(accel_y, offset_reg[1]);
                corr_reg[2] <= sat_sample(accel_z, offset_reg[2]);
            end
            ST_UPDATE:
            begin
                // load divider with sign and magnitude of the new sums
                for (int a = 0; a < AXES; a++)
                begin
                    neg_reg[a] <= sum_next[a][SUM_W-1];
                    quo_reg[a] <= sum_next[a][SUM_W-1] ? MAG_W'(-sum_next[a])
                                                        : MAG_W'(sum_next[a]);
                    rem_reg[a] <= '0;
                end
                step_reg <= '0;
            end
            ST_DIVIDE:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    logic [CNT_W:0] rs;
                    logic           ge;
                    rs = {rem_reg[a], quo_reg[a][MAG_W-1]};
                    ge = (rs >= {1'b0, fill_reg});
                    rem_reg[a] <= ge ? CNT_W'(rs - {1'b0, fill_reg}) : CNT_W'(rs);
                    quo_reg[a] <= {quo_reg[a][MAG_W-2:0], ge};
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_MEAN:
            begin
                // sign-magnitude divide truncates toward zero
                for (int a = 0; a < AXES; a++)
                    mean_reg[a] <= neg_reg[a] ? -quo_reg[a][SAMPLE_BITS-1:0]
                                              : quo_reg[a][SAMPLE_BITS-1:0];
            end
            ST_DELTA:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    logic signed [DMAG_W-1:0] d;
                    d = DMAG_W'(mean_reg[a]) - DMAG_W'(prev_reg[a]);
                    dmag_reg[a] <= d[DMAG_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
                end
                ax_reg    <= '0;
                total_reg <= '0;
            end
            ST_SQUARE:
            begin
                // one shared multiplier, product registered before the add
                if (ax_reg != AX_LAST)
                    prod_reg <= TOT_W'(dmag_reg[ax_reg]) * TOT_W'(dmag_reg[ax_reg]);
                if (ax_reg != '0)
                    total_reg <= total_reg + prod_reg;
                ax_reg <= ax_reg + AX_W'(1);
            end
            default: ;
        endcase

        if (out_load)
        begin
            collision_reg <= (total_ext > CMP_W'(threshold_reg));
            change_reg    <= (total_ext > CMP_W'(CHANGE_MAX)) ? CHANGE_MAX
                                                              : total_ext[OUT_W-1:0];
        end
    end

    assign total_ext = CMP_W'(total_reg);

    assign out_valid = out_valid_reg;
    assign collision = collision_reg;
    assign change_sq = change_reg;

    // while the window fills, the write slot tracks the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FILL_FULL) |-> (CNT_W'(slot_reg) == fill_reg))
        else $error("write slot out of step with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond window");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_UPDATE))
        else $error("accepted sample not processed");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (fill_reg != '0))
        else $error("window empty after update");

endmodule

`default_nettype wire
